// ----- rtl/sscg_pkg.sv -----
// shared widths, register indexes and reset values for the silhouette contrast gate
`timescale 1ns / 1ps
`default_nettype none
package sscg_pkg;

    localparam int MAX_DIM     = 1024;
    localparam int ALPHA_W     = 8;
    localparam int CHAN_W      = 8;
    localparam int LUMA_W      = 8;
    localparam int DIM_PORT_W  = 11;
    localparam int COUNT_W     = 21;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 21;
    localparam int LUMA_SUM_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_BOUND_ALPHA = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_AREA_ALPHA  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_WIDTH   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_HEIGHT  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PIXELS  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_LUMA    = 3'd6;

    localparam logic [ALPHA_W-1:0]    RST_BOUND_ALPHA = 8'd16;
    localparam logic [ALPHA_W-1:0]    RST_AREA_ALPHA  = 8'd32;
    localparam logic [DIM_PORT_W-1:0] RST_IMAGE_WIDTH = 11'd420;
    localparam logic [DIM_PORT_W-1:0] RST_MIN_WIDTH   = 11'd24;
    localparam logic [DIM_PORT_W-1:0] RST_MIN_HEIGHT  = 11'd24;
    localparam logic [COUNT_W-1:0]    RST_MIN_PIXELS  = 21'd220;
    localparam logic [LUMA_W-1:0]     RST_MIN_LUMA    = 8'd18;

    localparam logic [LUMA_SUM_W-1:0] LUMA_K_RED   = 16'd54;
    localparam logic [LUMA_SUM_W-1:0] LUMA_K_GREEN = 16'd183;
    localparam logic [LUMA_SUM_W-1:0] LUMA_K_BLUE  = 16'd19;

endpackage
`default_nettype wire

// ----- rtl/sprite_silhouette_contrast_gate.sv -----
// top level of the sprite silhouette contrast gate: config registers, front, queue, back
`timescale 1ns / 1ps
`default_nettype none
// Takes one RGBA pixel per cycle in raster order and, on the pixel flagged frame_end,
// queues one result: alpha bounding box width and height, count of opaque pixels
// (saturating), luma spread of those pixels, four below-minimum flags and a pass bit.
// A pixel transaction is accepted whenever the four-entry queue between the front end
// (position and classification) and the back end (accumulation) has room, so the
// sustained rate is one pixel per clock unless the back end stalls; a result passes
// through that queue and the back end into a two-entry result queue, where it waits.
// The back end stalls only on a last pixel while the result queue is full. Write
// configuration only while the block is idle; the config channel is always ready.
// Images up to MAX_DIM rows and columns.
module sprite_silhouette_contrast_gate (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_push,
    output logic                                   o_full,
    input  wire logic [sscg_pkg::ALPHA_W-1:0]      i_alpha,
    input  wire logic [sscg_pkg::CHAN_W-1:0]       i_red,
    input  wire logic [sscg_pkg::CHAN_W-1:0]       i_green,
    input  wire logic [sscg_pkg::CHAN_W-1:0]       i_blue,
    input  wire logic                              i_frame_end,
    output logic                                   o_empty,
    input  wire logic                              i_pop,
    output logic [sscg_pkg::DIM_PORT_W-1:0]        o_visible_width,
    output logic [sscg_pkg::DIM_PORT_W-1:0]        o_visible_height,
    output logic [sscg_pkg::COUNT_W-1:0]           o_visible_pixels,
    output logic [sscg_pkg::LUMA_W-1:0]            o_luma_spread,
    output logic                                   o_too_narrow,
    output logic                                   o_too_short,
    output logic                                   o_too_small_area,
    output logic                                   o_low_contrast,
    output logic                                   o_pass,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [sscg_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire logic [sscg_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import sscg_pkg::*;

    localparam int CW        = $clog2(MAX_DIM);
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 2;
    localparam int MW        = 3 + LUMA_W + 2 * CW;

    logic [ALPHA_W-1:0]    r_bound_alpha, r_area_alpha;
    logic [DIM_PORT_W-1:0] r_image_width, r_width_floor, r_height_floor;
    logic [COUNT_W-1:0]    r_min_pixels;
    logic [LUMA_W-1:0]     r_luma_floor;

    logic              w_accept, w_cfg_write;
    logic              f_box_hit, f_area_hit, f_last;
    logic [LUMA_W-1:0] f_luma;
    logic [CW-1:0]     f_col, f_row;
    logic [MW-1:0]     w_mid_in, w_mid_out;
    logic              w_mid_empty, w_take;
    logic              b_box_hit, b_area_hit, b_last;
    logic [LUMA_W-1:0] b_luma;
    logic [CW-1:0]     b_col, b_row;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_write = i_cfg_valid && o_cfg_ready;
    assign w_accept    = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bound_alpha  <= RST_BOUND_ALPHA;
            r_area_alpha   <= RST_AREA_ALPHA;
            r_image_width  <= RST_IMAGE_WIDTH;
            r_width_floor  <= RST_MIN_WIDTH;
            r_height_floor <= RST_MIN_HEIGHT;
            r_min_pixels   <= RST_MIN_PIXELS;
            r_luma_floor   <= RST_MIN_LUMA;
        end else if (w_cfg_write) begin
            unique case (i_cfg_index)
                REG_BOUND_ALPHA: r_bound_alpha  <= i_cfg_data[ALPHA_W-1:0];
                REG_AREA_ALPHA:  r_area_alpha   <= i_cfg_data[ALPHA_W-1:0];
                REG_IMAGE_WIDTH: r_image_width  <= i_cfg_data[DIM_PORT_W-1:0];
                REG_MIN_WIDTH:   r_width_floor  <= i_cfg_data[DIM_PORT_W-1:0];
                REG_MIN_HEIGHT:  r_height_floor <= i_cfg_data[DIM_PORT_W-1:0];
                REG_MIN_PIXELS:  r_min_pixels   <= i_cfg_data[COUNT_W-1:0];
                REG_MIN_LUMA:    r_luma_floor   <= i_cfg_data[LUMA_W-1:0];
                default: ;
            endcase
        end
    end

    sscg_front #(
        .MAX_DIM (MAX_DIM),
        .CW      (CW)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_bound_alpha (r_bound_alpha),
        .i_area_alpha  (r_area_alpha),
        .i_image_width (r_image_width),
        .i_alpha       (i_alpha),
        .i_red         (i_red),
        .i_green       (i_green),
        .i_blue        (i_blue),
        .i_frame_end   (i_frame_end),
        .o_box_hit     (f_box_hit),
        .o_area_hit    (f_area_hit),
        .o_luma        (f_luma),
        .o_col         (f_col),
        .o_row         (f_row),
        .o_last        (f_last)
    );

    assign w_mid_in = {f_last, f_box_hit, f_area_hit, f_luma, f_col, f_row};

    sscg_queue #(
        .WIDTH (MW),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_mid_in),
        .o_full  (o_full),
        .i_pop   (w_take),
        .o_data  (w_mid_out),
        .o_empty (w_mid_empty)
    );

    assign {b_last, b_box_hit, b_area_hit, b_luma, b_col, b_row} = w_mid_out;

    sscg_back #(
        .MAX_DIM   (MAX_DIM),
        .CW        (CW),
        .OUT_DEPTH (OUT_DEPTH)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (!w_mid_empty),
        .o_take           (w_take),
        .i_box_hit        (b_box_hit),
        .i_area_hit       (b_area_hit),
        .i_luma           (b_luma),
        .i_col            (b_col),
        .i_row            (b_row),
        .i_last           (b_last),
        .i_pop            (i_pop),
        .o_empty          (o_empty),
        .o_visible_width  (o_visible_width),
        .o_visible_height (o_visible_height),
        .o_visible_pixels (o_visible_pixels),
        .o_luma_spread    (o_luma_spread)
    );

    // user keeps thresholds stable while a result waits, not enforced by the block; flags use the queue head
    assign o_too_narrow     = (o_visible_width < r_width_floor);
    assign o_too_short      = (o_visible_height < r_height_floor);
    assign o_too_small_area = (o_visible_pixels < r_min_pixels);
    assign o_low_contrast   = (o_luma_spread < r_luma_floor);
    assign o_pass = !(o_too_narrow || o_too_short || o_too_small_area || o_low_contrast);
endmodule
`default_nettype wire

// ----- rtl/sscg_queue.sv -----
// small first-in first-out queue with count based full and empty
`timescale 1ns / 1ps
`default_nettype none
module sscg_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [NW-1:0]    r_count;
    logic             w_push, w_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- rtl/sscg_front.sv -----
// front end: raster position tracking, alpha classification and luma
`timescale 1ns / 1ps
`default_nettype none
module sscg_front #(
    parameter int MAX_DIM = 1024,
    parameter int CW      = 10
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire logic [sscg_pkg::ALPHA_W-1:0]     i_bound_alpha,
    input  wire logic [sscg_pkg::ALPHA_W-1:0]     i_area_alpha,
    input  wire logic [sscg_pkg::DIM_PORT_W-1:0]  i_image_width,
    input  wire logic [sscg_pkg::ALPHA_W-1:0]     i_alpha,
    input  wire logic [sscg_pkg::CHAN_W-1:0]      i_red,
    input  wire logic [sscg_pkg::CHAN_W-1:0]      i_green,
    input  wire logic [sscg_pkg::CHAN_W-1:0]      i_blue,
    input  wire logic                             i_frame_end,
    output logic                                  o_box_hit,
    output logic                                  o_area_hit,
    output logic [sscg_pkg::LUMA_W-1:0]           o_luma,
    output logic [CW-1:0]                         o_col,
    output logic [CW-1:0]                         o_row,
    output logic                                  o_last
);
    import sscg_pkg::*;

    localparam int XW = (CW + 1 > DIM_PORT_W) ? CW + 1 : DIM_PORT_W;

    logic [CW-1:0]         r_col, r_row, n_col, n_row;
    logic [XW-1:0]         w_col_inc;
    logic                  w_wrap;
    logic [LUMA_SUM_W-1:0] w_luma_sum;

    assign w_luma_sum = LUMA_K_RED   * LUMA_SUM_W'(i_red)
                      + LUMA_K_GREEN * LUMA_SUM_W'(i_green)
                      + LUMA_K_BLUE  * LUMA_SUM_W'(i_blue);

    assign o_box_hit  = (i_alpha > i_bound_alpha);
    assign o_area_hit = (i_alpha > i_area_alpha);
    assign o_luma     = w_luma_sum[LUMA_SUM_W-1 -: LUMA_W];
    assign o_col      = r_col;
    assign o_row      = r_row;
    assign o_last     = i_frame_end;

    // zero width acts as one, width above the limit acts as the limit
    assign w_col_inc = XW'(r_col) + XW'(1);
    assign w_wrap    = (w_col_inc >= XW'(i_image_width)) || (r_col == CW'(MAX_DIM - 1));

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_frame_end) begin
            n_col = '0;
            n_row = '0;
        end else if (w_wrap) begin
            n_col = '0;
            if (r_row != CW'(MAX_DIM - 1)) begin
                n_row = r_row + 1'b1;
            end
        end else begin
            n_col = r_col + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/sscg_back.sv -----
// back end: bounding box, count and luma range accumulation, result queue
`timescale 1ns / 1ps
`default_nettype none
module sscg_back #(
    parameter int MAX_DIM   = 1024,
    parameter int CW        = 10,
    parameter int OUT_DEPTH = 2
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    output logic                                  o_take,
    input  wire logic                             i_box_hit,
    input  wire logic                             i_area_hit,
    input  wire logic [sscg_pkg::LUMA_W-1:0]      i_luma,
    input  wire logic [CW-1:0]                    i_col,
    input  wire logic [CW-1:0]                    i_row,
    input  wire logic                             i_last,
    input  wire logic                             i_pop,
    output logic                                  o_empty,
    output logic [sscg_pkg::DIM_PORT_W-1:0]       o_visible_width,
    output logic [sscg_pkg::DIM_PORT_W-1:0]       o_visible_height,
    output logic [sscg_pkg::COUNT_W-1:0]          o_visible_pixels,
    output logic [sscg_pkg::LUMA_W-1:0]           o_luma_spread
);
    import sscg_pkg::*;

    localparam int RW = 2 * DIM_PORT_W + COUNT_W + LUMA_W;

    logic [CW-1:0]      r_left, r_top, r_right, r_bottom;
    logic [CW-1:0]      n_left, n_top, n_right, n_bottom;
    logic [CW-1:0]      u_left, u_top, u_right, u_bottom;
    logic               r_seen, n_seen, u_seen;
    logic [COUNT_W-1:0] r_count, n_count, u_count;
    logic [LUMA_W-1:0]  r_luma_lo, r_luma_hi, n_luma_lo, n_luma_hi, u_luma_lo, u_luma_hi;
    logic [CW:0]        w_span_x, w_span_y;
    logic [DIM_PORT_W-1:0] w_vw, w_vh;
    logic [LUMA_W-1:0]  w_spread;
    logic               w_oq_full, w_take;
    logic [RW-1:0]      w_oq_in, w_oq_out;

    assign w_take = i_valid && (!i_last || !w_oq_full);
    assign o_take = w_take;

    always_comb begin
        u_left    = r_left;
        u_top     = r_top;
        u_right   = r_right;
        u_bottom  = r_bottom;
        u_seen    = r_seen;
        u_count   = r_count;
        u_luma_lo = r_luma_lo;
        u_luma_hi = r_luma_hi;
        if (i_box_hit) begin
            if (!r_seen || i_col < r_left)   u_left   = i_col;
            if (!r_seen || i_row < r_top)    u_top    = i_row;
            if (!r_seen || i_col > r_right)  u_right  = i_col;
            if (!r_seen || i_row > r_bottom) u_bottom = i_row;
            u_seen = 1'b1;
        end
        if (i_area_hit) begin
            if (r_count != '1) u_count = r_count + 1'b1;
            if (i_luma < r_luma_lo) u_luma_lo = i_luma;
            if (i_luma > r_luma_hi) u_luma_hi = i_luma;
        end
    end

    assign w_span_x = {1'b0, u_right} - {1'b0, u_left} + (CW + 1)'(1);
    assign w_span_y = {1'b0, u_bottom} - {1'b0, u_top} + (CW + 1)'(1);
    assign w_vw     = u_seen ? DIM_PORT_W'(w_span_x) : '0;
    assign w_vh     = u_seen ? DIM_PORT_W'(w_span_y) : '0;
    assign w_spread = (u_count != '0) ? u_luma_hi - u_luma_lo : '0;
    assign w_oq_in  = {w_vw, w_vh, u_count, w_spread};

    always_comb begin
        if (i_last) begin
            n_left    = CW'(MAX_DIM - 1);
            n_top     = CW'(MAX_DIM - 1);
            n_right   = '0;
            n_bottom  = '0;
            n_seen    = 1'b0;
            n_count   = '0;
            n_luma_lo = '1;
            n_luma_hi = '0;
        end else begin
            n_left    = u_left;
            n_top     = u_top;
            n_right   = u_right;
            n_bottom  = u_bottom;
            n_seen    = u_seen;
            n_count   = u_count;
            n_luma_lo = u_luma_lo;
            n_luma_hi = u_luma_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left    <= CW'(MAX_DIM - 1);
            r_top     <= CW'(MAX_DIM - 1);
            r_right   <= '0;
            r_bottom  <= '0;
            r_seen    <= 1'b0;
            r_count   <= '0;
            r_luma_lo <= '1;
            r_luma_hi <= '0;
        end else if (w_take) begin
            r_left    <= n_left;
            r_top     <= n_top;
            r_right   <= n_right;
            r_bottom  <= n_bottom;
            r_seen    <= n_seen;
            r_count   <= n_count;
            r_luma_lo <= n_luma_lo;
            r_luma_hi <= n_luma_hi;
        end
    end

    sscg_queue #(
        .WIDTH (RW),
        .DEPTH (OUT_DEPTH)
    ) u_result_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_take && i_last),
        .i_data  (w_oq_in),
        .o_full  (w_oq_full),
        .i_pop   (i_pop),
        .o_data  (w_oq_out),
        .o_empty (o_empty)
    );

    assign {o_visible_width, o_visible_height, o_visible_pixels, o_luma_spread} = w_oq_out;
endmodule
`default_nettype wire
